// File: rtl/png_scanline_unfilter_to_argb_defines.svh
// Assertion helpers shared by the RTL files.
`ifndef PNG_SCANLINE_UNFILTER_TO_ARGB_DEFINES_SVH
`define PNG_SCANLINE_UNFILTER_TO_ARGB_DEFINES_SVH

// The condition holds at every clock edge outside reset.
`define PNGUNF_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define PNGUNF_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define PNGUNF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/pngunf_pkg.sv
package pngunf_pkg;

    localparam int MAX_WIDTH   = 240;
    localparam int MAX_HEIGHT  = 320;
    localparam int STORE_DEPTH = MAX_WIDTH * 4;
    localparam int COL_W       = $clog2(STORE_DEPTH);
    localparam int ROW_W       = 9;

    localparam logic [2:0] FILT_NONE  = 3'd0;
    localparam logic [2:0] FILT_SUB   = 3'd1;
    localparam logic [2:0] FILT_UP    = 3'd2;
    localparam logic [2:0] FILT_AVG   = 3'd3;
    localparam logic [2:0] FILT_PAETH = 3'd4;

    localparam logic [1:0] MODE_GRAY = 2'd0;
    localparam logic [1:0] MODE_RGB  = 2'd1;
    localparam logic [1:0] MODE_RGBA = 2'd2;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_MODE   = 2'd2;

    typedef struct packed {
        logic             en;
        logic [COL_W-1:0] addr;
        logic [7:0]       data;
    } store_wr_t;

    function automatic logic [2:0] bytes_per_pixel(input logic [1:0] mode);
        logic [2:0] bpp;
        if (mode == MODE_RGBA)
        begin
            bpp = 3'd4;
        end
        else if (mode == MODE_RGB)
        begin
            bpp = 3'd3;
        end
        else
        begin
            bpp = 3'd1;
        end
        return bpp;
    endfunction

endpackage

// File: rtl/png_scanline_unfilter_to_argb.sv
// Channel | Direction | Signals
// in      | in        | in_valid, in_stall, byte_value
// out     | out       | out_valid, out_stall, pixel_* , last_in_row, last_in_image, bad_filter
// cfg     | in        | cfg_valid, cfg_ready, cfg_index, cfg_data
// One byte is accepted per cycle when not stalled; a result is registered by its last byte.
// The previous-row byte is read from the row store ahead of its use, at the next column.
// Reset clears all control state; the row store needs no clearing pass after reset.
// Input stalls only while the output register holds a result that is itself stalled.
`include "png_scanline_unfilter_to_argb_defines.svh"

module png_scanline_unfilter_to_argb
    import pngunf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       byte_value,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       pixel_blue,
    output logic [7:0]       pixel_green,
    output logic [7:0]       pixel_red,
    output logic [7:0]       pixel_alpha,
    output logic [7:0]       pixel_column,
    output logic [ROW_W-1:0] pixel_row,
    output logic             last_in_row,
    output logic             last_in_image,
    output logic             bad_filter,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [8:0]       cfg_data
);

    logic [7:0]       width_reg;
    logic [ROW_W-1:0] height_reg;
    logic [1:0]       mode_reg;

    logic [31:0]      left_reg;
    logic [31:0]      left_next;
    logic [31:0]      upper_reg;
    logic [31:0]      upper_next;
    logic [23:0]      partial_reg;
    logic [23:0]      partial_next;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [1:0]       mod3_reg;
    logic [1:0]       mod3_next;
    logic [COL_W-1:0] div3_reg;
    logic [COL_W-1:0] div3_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [2:0]       filter_reg;
    logic [2:0]       filter_next;
    logic             have_filter_reg;
    logic             have_filter_next;
    logic             error_flag_reg;
    logic             error_flag_next;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       blue_reg;
    logic [7:0]       green_reg;
    logic [7:0]       red_reg;
    logic [7:0]       alpha_reg;
    logic [7:0]       column_reg;
    logic [ROW_W-1:0] row_out_reg;
    logic             last_row_reg;
    logic             last_image_reg;
    logic             bad_reg;
    logic [7:0]       blue_next;
    logic [7:0]       green_next;
    logic [7:0]       red_next;
    logic [7:0]       alpha_next;
    logic [7:0]       column_next;
    logic             last_row_next;
    logic             last_image_next;
    logic             bad_next;
    logic             emit;

    logic             accept;
    logic             ignore;
    logic [ROW_W-1:0] eff_height;
    logic [7:0]       eff_width;
    logic [2:0]       bpp;
    logic [COL_W-1:0] stride;
    logic [1:0]       lane;
    logic [4:0]       shift;
    logic [7:0]       left_byte;
    logic [7:0]       corner_byte;
    logic [7:0]       above_byte;
    logic [7:0]       pred;
    logic [7:0]       recon;
    logic             pix_end;
    logic             row_end;
    logic [ROW_W:0]   row_inc;
    store_wr_t        store_wr;

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 8'(MAX_WIDTH);
            height_reg <= ROW_W'(MAX_HEIGHT);
            mode_reg   <= MODE_RGBA;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_data[7:0];
                CFG_HEIGHT: height_reg <= cfg_data[ROW_W-1:0];
                CFG_MODE:   mode_reg   <= cfg_data[1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        eff_height = (height_reg > ROW_W'(MAX_HEIGHT)) ? ROW_W'(MAX_HEIGHT) : height_reg;
        priority if (width_reg == 8'd0)
        begin
            eff_width = 8'd1;
        end
        else if (width_reg > 8'(MAX_WIDTH))
        begin
            eff_width = 8'(MAX_WIDTH);
        end
        else
        begin
            eff_width = width_reg;
        end
        bpp = bytes_per_pixel(mode_reg);
        unique case (bpp)
            3'd4:    stride = {eff_width, 2'b00};
            3'd3:    stride = COL_W'({eff_width, 1'b0}) + COL_W'(eff_width);
            default: stride = COL_W'(eff_width);
        endcase
        unique case (bpp)
            3'd4:    lane = col_reg[1:0];
            3'd3:    lane = mod3_reg;
            default: lane = 2'd0;
        endcase
        shift       = {lane, 3'b000};
        left_byte   = left_reg[shift +: 8];
        corner_byte = upper_reg[shift +: 8];
    end

    pngunf_row_store u_store
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (store_wr),
        .rd_addr    (col_next),
        .above_byte (above_byte)
    );

    pngunf_predict u_predict
    (
        .filter_type (filter_reg),
        .left_byte   (left_byte),
        .above_byte  (above_byte),
        .corner_byte (corner_byte),
        .pred        (pred)
    );

    assign recon = byte_value + pred;

    always_comb
    begin
        ignore           = error_flag_reg || (row_reg >= eff_height);
        left_next        = left_reg;
        upper_next       = upper_reg;
        partial_next     = partial_reg;
        col_next         = col_reg;
        mod3_next        = mod3_reg;
        div3_next        = div3_reg;
        row_next         = row_reg;
        filter_next      = filter_reg;
        have_filter_next = have_filter_reg;
        error_flag_next  = error_flag_reg;
        store_wr.en      = 1'b0;
        store_wr.addr    = col_reg;
        store_wr.data    = recon;
        emit             = 1'b0;
        blue_next        = 8'd0;
        green_next       = 8'd0;
        red_next         = 8'd0;
        alpha_next       = 8'd0;
        column_next      = 8'd0;
        last_row_next    = 1'b0;
        last_image_next  = 1'b0;
        bad_next         = 1'b0;
        pix_end          = ({1'b0, lane} + 3'd1) == bpp;
        row_end          = (col_reg + COL_W'(1)) >= stride;
        row_inc          = {1'b0, row_reg} + (ROW_W+1)'(1);
        if (accept && !ignore)
        begin
            if (!have_filter_reg)
            begin
                have_filter_next = 1'b1;
                col_next         = '0;
                mod3_next        = 2'd0;
                div3_next        = '0;
                left_next        = '0;
                upper_next       = '0;
                partial_next     = '0;
                filter_next      = byte_value[2:0];
                if (byte_value > 8'(FILT_PAETH))
                begin
                    error_flag_next = 1'b1;
                    emit            = 1'b1;
                    bad_next        = 1'b1;
                end
            end
            else
            begin
                store_wr.en          = 1'b1;
                left_next[shift +: 8]  = recon;
                upper_next[shift +: 8] = above_byte;
                if (lane != 2'd3)
                begin
                    partial_next[shift +: 8] = recon;
                end
                if (pix_end)
                begin
                    emit = 1'b1;
                    unique case (bpp)
                        3'd4:
                        begin
                            blue_next  = partial_next[23:16];
                            green_next = partial_next[15:8];
                            red_next   = partial_next[7:0];
                            alpha_next = recon;
                        end
                        3'd3:
                        begin
                            blue_next  = partial_next[23:16];
                            green_next = partial_next[15:8];
                            red_next   = partial_next[7:0];
                            alpha_next = 8'hFF;
                        end
                        default:
                        begin
                            blue_next  = partial_next[7:0];
                            green_next = partial_next[7:0];
                            red_next   = partial_next[7:0];
                            alpha_next = 8'hFF;
                        end
                    endcase
                    unique case (bpp)
                        3'd4:    column_next = col_reg[9:2];
                        3'd3:    column_next = div3_reg[7:0];
                        default: column_next = col_reg[7:0];
                    endcase
                    last_row_next   = row_end;
                    last_image_next = row_end && (row_inc >= {1'b0, eff_height});
                end
                if (row_end)
                begin
                    row_next         = row_inc[ROW_W-1:0];
                    have_filter_next = 1'b0;
                    col_next         = '0;
                    mod3_next        = 2'd0;
                    div3_next        = '0;
                    left_next        = '0;
                    upper_next       = '0;
                    partial_next     = '0;
                end
                else
                begin
                    col_next = col_reg + COL_W'(1);
                    if (mod3_reg == 2'd2)
                    begin
                        mod3_next = 2'd0;
                        div3_next = div3_reg + COL_W'(1);
                    end
                    else
                    begin
                        mod3_next = mod3_reg + 2'd1;
                    end
                end
            end
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg        <= '0;
            upper_reg       <= '0;
            partial_reg     <= '0;
            col_reg         <= '0;
            mod3_reg        <= 2'd0;
            div3_reg        <= '0;
            row_reg         <= '0;
            filter_reg      <= FILT_NONE;
            have_filter_reg <= 1'b0;
            error_flag_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            left_reg        <= left_next;
            upper_reg       <= upper_next;
            partial_reg     <= partial_next;
            col_reg         <= col_next;
            mod3_reg        <= mod3_next;
            div3_reg        <= div3_next;
            row_reg         <= row_next;
            filter_reg      <= filter_next;
            have_filter_reg <= have_filter_next;
            error_flag_reg  <= error_flag_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            blue_reg       <= blue_next;
            green_reg      <= green_next;
            red_reg        <= red_next;
            alpha_reg      <= alpha_next;
            column_reg     <= column_next;
            row_out_reg    <= row_reg;
            last_row_reg   <= last_row_next;
            last_image_reg <= last_image_next;
            bad_reg        <= bad_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pixel_blue    = blue_reg;
    assign pixel_green   = green_reg;
    assign pixel_red     = red_reg;
    assign pixel_alpha   = alpha_reg;
    assign pixel_column  = column_reg;
    assign pixel_row     = row_out_reg;
    assign last_in_row   = last_row_reg;
    assign last_in_image = last_image_reg;
    assign bad_filter    = bad_reg;

    `PNGUNF_ASSERT_NEXT(a_error_sticky, error_flag_reg, error_flag_reg, "error flag cleared")
    `PNGUNF_ASSERT_IMPL(a_bad_has_error, out_valid_reg && bad_reg, error_flag_reg, "bad filter without error")
    `PNGUNF_ASSERT_IMPL(a_col_in_row, have_filter_reg, col_reg < COL_W'(STORE_DEPTH), "column past store")

endmodule

// File: rtl/pngunf_predict.sv
module pngunf_predict
    import pngunf_pkg::*;
(
    input  logic [2:0] filter_type,
    input  logic [7:0] left_byte,
    input  logic [7:0] above_byte,
    input  logic [7:0] corner_byte,
    output logic [7:0] pred
);

    logic signed [10:0] pa_s;
    logic signed [10:0] pb_s;
    logic signed [10:0] pc_s;
    logic [10:0]        pa;
    logic [10:0]        pb;
    logic [10:0]        pc;
    logic [7:0]         paeth;
    logic [8:0]         avg_sum;

    always_comb
    begin
        pa_s = $signed({3'b000, above_byte}) - $signed({3'b000, corner_byte});
        pb_s = $signed({3'b000, left_byte}) - $signed({3'b000, corner_byte});
        pc_s = pa_s + pb_s;
        pa   = pa_s[10] ? 11'(-pa_s) : 11'(pa_s);
        pb   = pb_s[10] ? 11'(-pb_s) : 11'(pb_s);
        pc   = pc_s[10] ? 11'(-pc_s) : 11'(pc_s);
        priority if (pa <= pb && pa <= pc)
        begin
            paeth = left_byte;
        end
        else if (pb <= pc)
        begin
            paeth = above_byte;
        end
        else
        begin
            paeth = corner_byte;
        end
        avg_sum = {1'b0, left_byte} + {1'b0, above_byte};
        unique case (filter_type)
            FILT_SUB:   pred = left_byte;
            FILT_UP:    pred = above_byte;
            FILT_AVG:   pred = avg_sum[8:1];
            FILT_PAETH: pred = paeth;
            default:    pred = 8'd0;
        endcase
    end

endmodule

// File: rtl/pngunf_row_store.sv
`include "png_scanline_unfilter_to_argb_defines.svh"

module pngunf_row_store
    import pngunf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  store_wr_t        wr,
    input  logic [COL_W-1:0] rd_addr,
    output logic [7:0]       above_byte
);

    logic [7:0]       mem [STORE_DEPTH];
    logic [7:0]       rd_data_reg;
    logic [COL_W-1:0] rd_addr_reg;
    logic [COL_W-1:0] fill_reg;
    logic [COL_W-1:0] fill_next;
    logic             fwd_hit_reg;
    logic [7:0]       fwd_data_reg;

    // Entries are always written as a growing prefix, so a fill mark stands in for a clear.
    always_comb
    begin
        fill_next = fill_reg;
        if (wr.en && wr.addr >= fill_reg)
        begin
            fill_next = wr.addr + COL_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg  <= mem[rd_addr];
        fwd_data_reg <= wr.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_addr_reg <= '0;
            fill_reg    <= '0;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            rd_addr_reg <= rd_addr;
            fill_reg    <= fill_next;
            fwd_hit_reg <= wr.en && (wr.addr == rd_addr);
        end
    end

    always_comb
    begin
        priority if (fwd_hit_reg)
        begin
            above_byte = fwd_data_reg;
        end
        else if (rd_addr_reg < fill_reg)
        begin
            above_byte = rd_data_reg;
        end
        else
        begin
            above_byte = 8'd0;
        end
    end

    `PNGUNF_ASSERT_IMPL(a_write_in_prefix, wr.en, wr.addr <= fill_reg, "row store write skips entries")
    `PNGUNF_ASSERT_ALWAYS(a_fill_bound, fill_reg <= COL_W'(STORE_DEPTH), "fill mark past store")

endmodule

// File: verif/tb_png_scanline_unfilter_to_argb.sv
`timescale 1ns / 1ps

module tb_png_scanline_unfilter_to_argb;
    import pngunf_pkg::*;

    localparam int ITEMS      = 1900;
    localparam int ROW_BUDGET = 300;
    localparam int WATCHDOG   = 4000;
    localparam int SETTLE     = 4;
    localparam int DRAIN      = 16;
    localparam int PLAN_LEN   = 31;

    localparam logic [1:0] MODE_ALIAS_GRAY = 2'd3;

    typedef struct packed {
        logic [7:0]       blue;
        logic [7:0]       green;
        logic [7:0]       red;
        logic [7:0]       alpha;
        logic [7:0]       column;
        logic [ROW_W-1:0] row;
        logic             end_row;
        logic             end_image;
        logic             bad;
    } pixel_t;

    typedef enum bit {STEP_BYTE, STEP_REG} step_kind_t;

    typedef struct packed {
        step_kind_t kind;
        logic [1:0] reg_idx;
        logic [8:0] value;
        bit         has_want;
        pixel_t     want;
    } plan_step_t;

    localparam pixel_t NO_PIX = '0;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic [7:0]       byte_value;
    logic             out_valid;
    logic             out_stall;
    logic [7:0]       pixel_blue;
    logic [7:0]       pixel_green;
    logic [7:0]       pixel_red;
    logic [7:0]       pixel_alpha;
    logic [7:0]       pixel_column;
    logic [ROW_W-1:0] pixel_row;
    logic             last_in_row;
    logic             last_in_image;
    logic             bad_filter;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [1:0]       cfg_index;
    logic [8:0]       cfg_data;

    logic [7:0]  above_row [STORE_DEPTH];
    logic [31:0] left_px;
    logic [31:0] upleft_px;
    logic [23:0] partial_px;
    int unsigned col_pos;
    int unsigned row_pos;
    logic [2:0]  filt;
    bit          filt_seen;
    bit          err_seen;
    logic [7:0]  cfg_w;
    logic [8:0]  cfg_h;
    logic [1:0]  cfg_m;

    pixel_t      pending_pixels [$];
    plan_step_t  plan [PLAN_LEN];
    int unsigned mismatches = 0;
    int unsigned live_bytes = 0;
    int unsigned idle_cycles = 0;
    bit          gaps_on = 1'b0;
    bit          stalls_on = 1'b0;

    png_scanline_unfilter_to_argb dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .byte_value    (byte_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pixel_blue    (pixel_blue),
        .pixel_green   (pixel_green),
        .pixel_red     (pixel_red),
        .pixel_alpha   (pixel_alpha),
        .pixel_column  (pixel_column),
        .pixel_row     (pixel_row),
        .last_in_row   (last_in_row),
        .last_in_image (last_in_image),
        .bad_filter    (bad_filter),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    function automatic int unsigned bytes_in_pixel();
        if (cfg_m == MODE_RGBA)
        begin
            return 4;
        end
        if (cfg_m == MODE_RGB)
        begin
            return 3;
        end
        return 1;
    endfunction

    function automatic int unsigned pixels_in_row();
        if (cfg_w == 8'd0)
        begin
            return 1;
        end
        if (cfg_w > MAX_WIDTH)
        begin
            return MAX_WIDTH;
        end
        return cfg_w;
    endfunction

    function automatic int unsigned rows_in_image();
        return (cfg_h > MAX_HEIGHT) ? MAX_HEIGHT : cfg_h;
    endfunction

    function automatic bit byte_ignored();
        return err_seen || (row_pos >= rows_in_image());
    endfunction

    function automatic bit unfilter_byte(input logic [7:0] v, output pixel_t px);
        int unsigned bpp;
        int unsigned stride;
        int unsigned k;
        int unsigned sh;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  c;
        logic [7:0]  guess;
        logic [7:0]  x;
        int          p;
        int          pa;
        int          pb;
        int          pc;
        bit          pix_done;
        bit          row_done;
        px = NO_PIX;
        if (byte_ignored())
        begin
            return 1'b0;
        end
        if (!filt_seen)
        begin
            filt_seen  = 1'b1;
            col_pos    = 0;
            left_px    = '0;
            upleft_px  = '0;
            partial_px = '0;
            filt       = v[2:0];
            if (v > FILT_PAETH)
            begin
                err_seen = 1'b1;
                px.row   = ROW_W'(row_pos);
                px.bad   = 1'b1;
                return 1'b1;
            end
            return 1'b0;
        end
        bpp    = bytes_in_pixel();
        stride = pixels_in_row() * bpp;
        k      = col_pos % bpp;
        sh     = 8 * k;
        a      = left_px[sh +: 8];
        c      = upleft_px[sh +: 8];
        b      = (col_pos < STORE_DEPTH) ? above_row[col_pos] : 8'h00;
        case (filt)
            FILT_SUB:
            begin
                guess = a;
            end
            FILT_UP:
            begin
                guess = b;
            end
            FILT_AVG:
            begin
                guess = 8'((9'(a) + 9'(b)) >> 1);
            end
            FILT_PAETH:
            begin
                p  = int'(a) + int'(b) - int'(c);
                pa = p - int'(a);
                pb = p - int'(b);
                pc = p - int'(c);
                if (pa < 0)
                begin
                    pa = -pa;
                end
                if (pb < 0)
                begin
                    pb = -pb;
                end
                if (pc < 0)
                begin
                    pc = -pc;
                end
                if (pa <= pb && pa <= pc)
                begin
                    guess = a;
                end
                else if (pb <= pc)
                begin
                    guess = b;
                end
                else
                begin
                    guess = c;
                end
            end
            default:
            begin
                guess = 8'h00;
            end
        endcase
        x = v + guess;
        if (col_pos < STORE_DEPTH)
        begin
            above_row[col_pos] = x;
        end
        left_px[sh +: 8]   = x;
        upleft_px[sh +: 8] = b;
        if (k < 3)
        begin
            partial_px[sh +: 8] = x;
        end
        pix_done = (k + 1 == bpp);
        row_done = (col_pos + 1 >= stride);
        if (pix_done)
        begin
            if (bpp == 1)
            begin
                px.blue  = partial_px[7:0];
                px.green = partial_px[7:0];
                px.red   = partial_px[7:0];
                px.alpha = 8'hFF;
            end
            else
            begin
                px.blue  = partial_px[23:16];
                px.green = partial_px[15:8];
                px.red   = partial_px[7:0];
                px.alpha = (bpp == 4) ? x : 8'hFF;
            end
            px.column    = 8'(col_pos / bpp);
            px.row       = ROW_W'(row_pos);
            px.end_row   = row_done;
            px.end_image = row_done && (row_pos + 1 >= rows_in_image());
        end
        if (row_done)
        begin
            row_pos    = row_pos + 1;
            filt_seen  = 1'b0;
            col_pos    = 0;
            left_px    = '0;
            upleft_px  = '0;
            partial_px = '0;
        end
        else
        begin
            col_pos = col_pos + 1;
        end
        return pix_done;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 88)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(25, 60);
    endfunction

    function automatic logic [7:0] next_byte();
        int unsigned pick;
        if (byte_ignored())
        begin
            return 8'($urandom_range(0, 255));
        end
        if (!filt_seen)
        begin
            return 8'($urandom_range(FILT_NONE, FILT_PAETH));
        end
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            return 8'h00;
        end
        if (pick == 1)
        begin
            return 8'hFF;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // The sender stays quiet until every expected pixel has come back.
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_pixels.size() != 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [8:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_WIDTH:
            begin
                cfg_w = value[7:0];
            end
            CFG_HEIGHT:
            begin
                cfg_h = value;
            end
            CFG_MODE:
            begin
                cfg_m = value[1:0];
            end
            default:
            begin
            end
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_byte(input logic [7:0] v, input bit has_want, input pixel_t want);
        pixel_t      got_px;
        bit          has_px;
        int unsigned gap;
        in_valid   <= 1'b1;
        byte_value <= v;
        do
            @(posedge clk);
        while (in_stall);
        if (!byte_ignored())
        begin
            live_bytes++;
        end
        has_px = unfilter_byte(v, got_px);
        if (has_px)
        begin
            pending_pixels.push_back(has_want ? want : got_px);
        end
        @(negedge clk);
        if (gaps_on)
        begin
            gap = pick_gap();
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    initial
    begin : stall_driver
        int unsigned hold;
        hold      = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                hold--;
            end
            else
            begin
                out_stall <= 1'b0;
                if (stalls_on && $urandom_range(0, 3) == 0)
                begin
                    hold = pick_gap();
                end
            end
        end
    end

    always @(posedge clk)
    begin : check_pixels
        pixel_t want_px;
        pixel_t got_px;
        if (rst_n && out_valid && !out_stall)
        begin
            got_px = '{pixel_blue, pixel_green, pixel_red, pixel_alpha, pixel_column,
                       pixel_row, last_in_row, last_in_image, bad_filter};
            if (pending_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected pixel at x=%0d y=%0d bad=%b",
                             pixel_column, pixel_row, bad_filter);
                end
            end
            else
            begin
                want_px = pending_pixels.pop_front();
                if (got_px !== want_px)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("pixel mismatch: expected %h %h %h %h x=%0d y=%0d flags=%b%b%b",
                                 want_px.blue, want_px.green, want_px.red, want_px.alpha,
                                 want_px.column, want_px.row, want_px.end_row,
                                 want_px.end_image, want_px.bad);
                        $display("                got      %h %h %h %h x=%0d y=%0d flags=%b%b%b",
                                 got_px.blue, got_px.green, got_px.red, got_px.alpha,
                                 got_px.column, got_px.row, got_px.end_row,
                                 got_px.end_image, got_px.bad);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int unsigned phase;
        int unsigned pick;
        int unsigned burst;
        logic [7:0]  new_w;
        logic [8:0]  new_h;
        logic [1:0]  new_m;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        byte_value = 8'h00;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_WIDTH;
        cfg_data   = 9'd0;
        cfg_w      = 8'(MAX_WIDTH);
        cfg_h      = 9'(MAX_HEIGHT);
        cfg_m      = MODE_RGBA;
        foreach (above_row[i])
        begin
            above_row[i] = 8'h00;
        end
        left_px    = '0;
        upleft_px  = '0;
        partial_px = '0;
        col_pos    = 0;
        row_pos    = 0;
        filt       = FILT_NONE;
        filt_seen  = 1'b0;
        err_seen   = 1'b0;

        plan = '{
            '{STEP_REG,  CFG_HEIGHT, 9'd1,              1'b0, NO_PIX},
            '{STEP_BYTE, CFG_WIDTH,  9'(FILT_NONE),     1'b0, NO_PIX},
            '{STEP_BYTE, CFG_WIDTH,  9'h00,             1'b0, NO_PIX},
            '{STEP_BYTE, CFG_WIDTH,  9'hFF,             1'b0, NO_PIX},
            '{STEP_BYTE, CFG_WIDTH,  9'h80,             1'b0, NO_PIX},
            '{STEP_BYTE, CFG_WIDTH,  9'h01,             1'b1,
              '{8'h80, 8'hFF, 8'h00, 8'h01, 8'd0, 9'd0, 1'b0, 1'b0, 1'b0}},
            '{STEP_BYTE, CFG_WIDTH,  9'h10,             1'b0, NO_PIX},
            '{STEP_REG,  CFG_WIDTH,  9'd1,              1'b0, NO_PIX},
            '{STEP_REG,  CFG_MODE,   9'(MODE_RGB),      1'b0, NO_PIX},
            '{STEP_BYTE, CFG_WIDTH,  9'h55,             1'b0, NO_PIX},
            '{STEP_BYTE, CFG_WIDTH,  9'hAA,             1'b0, NO_PIX},
            '{STEP_BYTE, CFG_WIDTH,  9'h00,             1'b0, NO_PIX},
            '{STEP_REG,  CFG_HEIGHT, 9'd0,              1'b0, NO_PIX},
            '{STEP_BYTE, CFG_WIDTH,  9'h04,             1'b0, NO_PIX},
            '{STEP_REG,  CFG_HEIGHT, 9'h1FF,            1'b0, NO_PIX},
            '{STEP_BYTE, CFG_WIDTH,  9'(FILT_SUB),      1'b0, NO_PIX},
            '{STEP_BYTE, CFG_WIDTH,  9'h01,             1'b0, NO_PIX},
            '{STEP_BYTE, CFG_WIDTH,  9'h02,             1'b0, NO_PIX},
            '{STEP_BYTE, CFG_WIDTH,  9'h03,             1'b1,
              '{8'h03, 8'h02, 8'h01, 8'hFF, 8'd0, 9'd1, 1'b1, 1'b0, 1'b0}},
            '{STEP_BYTE, CFG_WIDTH,  9'(FILT_UP),       1'b0, NO_PIX},
            '{STEP_BYTE, CFG_WIDTH,  9'hFF,             1'b0, NO_PIX},
            '{STEP_BYTE, CFG_WIDTH,  9'hFE,             1'b0, NO_PIX},
            '{STEP_BYTE, CFG_WIDTH,  9'h80,             1'b0, NO_PIX},
            '{STEP_REG,  CFG_WIDTH,  9'd2,              1'b0, NO_PIX},
            '{STEP_REG,  CFG_MODE,   9'(MODE_GRAY),     1'b0, NO_PIX},
            '{STEP_BYTE, CFG_WIDTH,  9'(FILT_AVG),      1'b0, NO_PIX},
            '{STEP_BYTE, CFG_WIDTH,  9'hFF,             1'b0, NO_PIX},
            '{STEP_BYTE, CFG_WIDTH,  9'h01,             1'b0, NO_PIX},
            '{STEP_BYTE, CFG_WIDTH,  9'(FILT_PAETH),    1'b0, NO_PIX},
            '{STEP_BYTE, CFG_WIDTH,  9'h7F,             1'b0, NO_PIX},
            '{STEP_BYTE, CFG_WIDTH,  9'hFF,             1'b0, NO_PIX}
        };

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n     = 1'b1;
        gaps_on   = 1'b1;
        stalls_on = 1'b1;

        for (int i = 0; i < PLAN_LEN; i++)
        begin
            if (plan[i].kind == STEP_REG)
            begin
                write_reg(plan[i].reg_idx, plan[i].value);
            end
            else
            begin
                push_byte(plan[i].value[7:0], plan[i].has_want, plan[i].want);
            end
        end

        // Each phase starts from a new setting, often in the middle of a row.
        phase = 0;
        while (live_bytes < ITEMS && row_pos < ROW_BUDGET)
        begin
            case (phase)
                0:
                begin
                    new_w = 8'd0;
                    new_m = MODE_ALIAS_GRAY;
                end
                1:
                begin
                    new_w = 8'd255;
                    new_m = MODE_GRAY;
                end
                2:
                begin
                    new_w = 8'(MAX_WIDTH);
                    new_m = MODE_RGBA;
                end
                default:
                begin
                    new_w = ($urandom_range(0, 9) == 0) ? 8'd1 : 8'($urandom_range(1, 6));
                    new_m = 2'($urandom_range(0, 3));
                end
            endcase
            pick = $urandom_range(0, 9);
            if (phase == 2 || pick >= 4)
            begin
                new_h = 9'h1FF;
            end
            else if (pick == 0)
            begin
                new_h = 9'd0;
            end
            else if (pick < 3)
            begin
                new_h = 9'(row_pos + $urandom_range(1, 2));
            end
            else
            begin
                new_h = 9'(MAX_HEIGHT);
            end
            write_reg(CFG_WIDTH, 9'(new_w));
            write_reg(CFG_HEIGHT, new_h);
            write_reg(CFG_MODE, 9'(new_m));
            gaps_on   = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            burst     = (phase == 2) ? 970 : $urandom_range(6, 40);
            repeat (burst)
            begin
                push_byte(next_byte(), 1'b0, NO_PIX);
            end
            phase++;
        end

        // The unknown filter is sticky, so it closes the stream.
        write_reg(CFG_HEIGHT, 9'h1FF);
        while (filt_seen)
        begin
            push_byte(next_byte(), 1'b0, NO_PIX);
        end
        push_byte(8'($urandom_range(FILT_PAETH + 1, 255)), 1'b0, NO_PIX);
        repeat (3)
        begin
            push_byte(next_byte(), 1'b0, NO_PIX);
        end
        write_reg(CFG_HEIGHT, 9'(MAX_HEIGHT));
        repeat (3)
        begin
            push_byte(next_byte(), 1'b0, NO_PIX);
        end
        in_valid <= 1'b0;

        while (pending_pixels.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN) @(negedge clk);
        if (mismatches == 0 && pending_pixels.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: png_scanline_unfilter_to_argb.f
+incdir+rtl
rtl/pngunf_pkg.sv
rtl/pngunf_predict.sv
rtl/pngunf_row_store.sv
rtl/png_scanline_unfilter_to_argb.sv
verif/tb_png_scanline_unfilter_to_argb.sv
